// File: sv/ipv4tp_pkg.sv
// Shared types, character codes and range checks for the IPv4 text parser.
package ipv4tp_pkg;

	localparam int CHAR_W   = 8;
	localparam int OCTET_W  = 10;
	localparam int ADDR_W   = 32;
	localparam int DCOUNT_W = 2;
	localparam int DOTS_W   = 3;
	localparam int OUT_W    = 40;

	localparam logic [CHAR_W-1:0]  CHAR_DOT  = 8'h2E;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;
	localparam logic [OCTET_W-1:0] OCTET_MAX = 10'd255;
	localparam logic [DCOUNT_W-1:0] DIGITS_MAX = 2'd3;
	localparam logic [DOTS_W-1:0]  DOTS_SAT  = 3'd4;
	localparam logic [DOTS_W-1:0]  DOTS_NEED = 3'd3;

	localparam logic [7:0] NET_A_OCT1    = 8'd10;
	localparam logic [7:0] NET_B_OCT1    = 8'd172;
	localparam logic [7:0] NET_B_OCT2_LO = 8'd16;
	localparam logic [7:0] NET_B_OCT2_HI = 8'd31;
	localparam logic [7:0] NET_C_OCT1    = 8'd192;
	localparam logic [7:0] NET_C_OCT2    = 8'd168;
	localparam logic [7:0] LOOPBACK_OCT1 = 8'd127;

	typedef struct packed {
		logic              is_private;
		logic [ADDR_W-1:0] address_value;
		logic              is_valid;
	} result_t;

	function automatic logic private_range(input logic [ADDR_W-1:0] addr);
		logic [7:0] o1;
		logic [7:0] o2;
		o1 = addr[31:24];
		o2 = addr[23:16];
		return (o1 == NET_A_OCT1) ||
			(o1 == NET_B_OCT1 && o2 >= NET_B_OCT2_LO && o2 <= NET_B_OCT2_HI) ||
			(o1 == NET_C_OCT1 && o2 == NET_C_OCT2) ||
			(o1 == LOOPBACK_OCT1);
	endfunction

endpackage

// File: sv/ipv4tp_parse.sv
// Per-character parse state and end-of-string result for the IPv4 text parser.
module ipv4tp_parse
	import ipv4tp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last_char,
	output result_t           result
);

	logic [OCTET_W-1:0]  octet_q, octet_n;
	logic [DCOUNT_W-1:0] digits_q, digits_n;
	logic [DOTS_W-1:0]   dots_q, dots_n;
	logic [ADDR_W-1:0]   addr_q, addr_n;
	logic                err_q, err_n;

	logic                is_dot, is_digit, err_f;
	logic [13:0]         times_ten;
	logic [ADDR_W-1:0]   addr_f;
	logic                valid_f;

	assign is_dot   = (char_code == CHAR_DOT);
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign times_ten = {1'b0, octet_q, 3'b000} + {3'b000, octet_q, 1'b0}
		+ {10'd0, char_code[3:0]};

	always_comb begin
		octet_n  = octet_q;
		digits_n = digits_q;
		dots_n   = dots_q;
		addr_n   = addr_q;
		err_n    = err_q;
		if (!err_q) begin
			if (is_dot) begin
				if (dots_q < DOTS_SAT)
					dots_n = dots_q + 3'd1;
				if (dots_n > DOTS_NEED || octet_q > OCTET_MAX)
					err_n = 1'b1;
				addr_n   = {addr_q[ADDR_W-9:0], octet_q[7:0]};
				octet_n  = '0;
				digits_n = '0;
			end else if (digits_q >= DIGITS_MAX || !is_digit) begin
				err_n = 1'b1;
			end else begin
				octet_n  = times_ten[OCTET_W-1:0];
				digits_n = digits_q + 2'd1;
			end
		end
	end

	// final octet closes on the string end
	always_comb begin
		err_f   = err_n || (octet_n > OCTET_MAX);
		addr_f  = {addr_n[ADDR_W-9:0], octet_n[7:0]};
		valid_f = !err_f && (dots_n == DOTS_NEED);
		result.is_valid      = valid_f;
		result.address_value = valid_f ? addr_f : '0;
		result.is_private    = valid_f && private_range(addr_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_q  <= '0;
			digits_q <= '0;
			dots_q   <= '0;
			addr_q   <= '0;
			err_q    <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				octet_q  <= '0;
				digits_q <= '0;
				dots_q   <= '0;
				addr_q   <= '0;
				err_q    <= 1'b0;
			end else begin
				octet_q  <= octet_n;
				digits_q <= digits_n;
				dots_q   <= dots_n;
				addr_q   <= addr_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

// File: sv/ipv4_text_parse_private_check_core.sv
// Top level of the IPv4 dotted-decimal parser with private-range check.
// Input stream: one ASCII character per request on s_axis_tdata, with
// s_axis_tlast high on the final character of the address string.
// Output stream: one request per string, issued for its final character,
// carrying is_valid, the 32-bit address (first octet in the top byte, zero
// when invalid) and is_private.
// Timing: a character sits in an input register, where the parse state and
// the end-of-string result are formed; the result is then held in an output
// register. One character is taken every cycle while s_axis_tready is high,
// limited only by the input register and the output register.
// Reset: arst_n clears the parse state and both valid flags; the next
// character starts a new string.
// Stall: while m_axis_tready is low, a held result stays put and
// characters keep flowing until another final character reaches the input
// register; it then waits there and s_axis_tready drops.
module ipv4_text_parse_private_check_core
	import ipv4tp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [CHAR_W-1:0] s_axis_tdata,  // [7:0] char_code
	input  logic              s_axis_tlast,  // last_char
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata   // [0] is_valid, [32:1] address_value,
	                                         // [33] is_private, [39:34] zero
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              out_free, go_s1;
	result_t           result;
	result_t           result_q;
	logic              out_valid_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign go_s1         = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ipv4tp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (go_s1),
		.char_code (char_s1),
		.last_char (last_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go_s1 && last_s1)
			result_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, result_q};

endmodule
